/* sv/vfeq_pkg.sv */
// ----------------------------------------------------------------------------
// vfeq_pkg
// Shared types and codes for the voxel face exposure query block.
// ----------------------------------------------------------------------------
package vfeq_pkg;

  // request codes on in_req_type
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // read sequence of one query: own cell first, then the six face neighbours
  typedef enum logic [2:0] {
    STEP_SELF,
    STEP_XM,
    STEP_XP,
    STEP_YM,
    STEP_YP,
    STEP_ZM,
    STEP_ZP
  } step_t;

  // fixed field widths of the channels
  localparam int unsigned X_W    = 4;
  localparam int unsigned Y_W    = 6;
  localparam int unsigned Z_W    = 4;
  localparam int unsigned KIND_W = 4;

endpackage

/* sv/voxel_face_exposure_query.sv */
// ----------------------------------------------------------------------------
// voxel_face_exposure_query
// Voxel kind store with a query that reports a cell's kind and whether any
// of its six face neighbours is empty or off the grid.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_ready  | req_type, x/y/z_pos, block_kind
//  out_    | output    | out_valid/out_ready| cell_kind, visible
//
//  a write is stored in the cycle of its transfer and leaves the block idle
//  a query runs in order: transfer, seven reads of the single-port store
//  (own cell and six neighbours, one per cycle), a drain state, then a load
//  of the output register; the single read port serialises the reads
//  the output register holds a result until taken; a later query waits in
//  its final state while the previous result is still held
//  reset clears control state only; the store is undefined until written
// ----------------------------------------------------------------------------
module voxel_face_exposure_query #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 64,
  parameter int KIND_BITS   = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [vfeq_pkg::X_W-1:0]    in_x_pos,
  input  logic [vfeq_pkg::Y_W-1:0]    in_y_pos,
  input  logic [vfeq_pkg::Z_W-1:0]    in_z_pos,
  input  logic [vfeq_pkg::KIND_W-1:0] in_block_kind,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vfeq_pkg::KIND_W-1:0] out_cell_kind,
  output logic                        out_visible
);
  import vfeq_pkg::*;

  localparam int PLANE  = GRID_WIDTH * GRID_WIDTH;
  localparam int DEPTH  = PLANE * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  // coordinate width with one bit of headroom for the +1 neighbour
  localparam int XC_W   = X_W + 1;
  localparam int YC_W   = Y_W + 1;
  localparam int ZC_W   = Z_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                state_r;
  step_t                 step_r;
  logic [X_W-1:0]        qx_r;
  logic [Y_W-1:0]        qy_r;
  logic [Z_W-1:0]        qz_r;
  logic                  rd_pend_r;
  step_t                 rd_step_r;
  logic                  rd_in_grid_r;
  logic [KIND_BITS-1:0]  kind_acc_r;
  logic                  vis_acc_r;
  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_cell_kind_r;
  logic                  out_visible_r;

  logic [KIND_BITS-1:0]  mem [DEPTH];
  logic [KIND_BITS-1:0]  mem_rdata_r;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [KIND_BITS-1:0]  mem_wdata;

  logic [XC_W-1:0]       nx;
  logic [YC_W-1:0]       ny;
  logic [ZC_W-1:0]       nz;
  logic                  under;
  logic                  n_in_grid;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_in_grid;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  in_xfer;
  logic                  out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_cell_kind = out_cell_kind_r;
  assign out_visible   = out_visible_r;

  // coordinates of the cell read in the current step
  always_comb begin
    nx    = XC_W'(qx_r);
    ny    = YC_W'(qy_r);
    nz    = ZC_W'(qz_r);
    under = 1'b0;
    case (step_r)
      STEP_SELF: ;
      STEP_XM: begin
        nx    = XC_W'(qx_r) - XC_W'(1);
        under = (qx_r == '0);
      end
      STEP_XP: nx = XC_W'(qx_r) + XC_W'(1);
      STEP_YM: begin
        ny    = YC_W'(qy_r) - YC_W'(1);
        under = (qy_r == '0);
      end
      STEP_YP: ny = YC_W'(qy_r) + YC_W'(1);
      STEP_ZM: begin
        nz    = ZC_W'(qz_r) - ZC_W'(1);
        under = (qz_r == '0);
      end
      STEP_ZP: nz = ZC_W'(qz_r) + ZC_W'(1);
      default: ;
    endcase
  end

  assign n_in_grid = !under && (int'(nx) < GRID_WIDTH) && (int'(nz) < GRID_WIDTH) &&
                     (int'(ny) < GRID_HEIGHT);
  assign rd_addr   = ADDR_W'(int'(ny) * PLANE + int'(nz) * GRID_WIDTH + int'(nx));

  assign wr_in_grid = (int'(in_x_pos) < GRID_WIDTH) && (int'(in_z_pos) < GRID_WIDTH) &&
                      (int'(in_y_pos) < GRID_HEIGHT);
  assign wr_addr    = ADDR_W'(int'(in_y_pos) * PLANE + int'(in_z_pos) * GRID_WIDTH +
                              int'(in_x_pos));

  // writes go straight in from the port; read data is only used outside idle
  assign mem_we    = in_xfer && (in_req_type == REQ_WRITE) && wr_in_grid;
  assign mem_addr  = (state_r == S_IDLE) ? wr_addr : rd_addr;
  assign mem_wdata = KIND_BITS'(in_block_kind);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_SELF;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_READ);
      rd_step_r <= step_r;
      rd_in_grid_r <= n_in_grid;

      // fold in the data read last cycle
      if (rd_pend_r) begin
        if (rd_step_r == STEP_SELF) begin
          kind_acc_r <= rd_in_grid_r ? mem_rdata_r : '0;
        end else if (!rd_in_grid_r || mem_rdata_r == '0) begin
          vis_acc_r <= 1'b1;
        end
      end

      // the final query state reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_req_type == REQ_QUERY) begin
            qx_r      <= in_x_pos;
            qy_r      <= in_y_pos;
            qz_r      <= in_z_pos;
            step_r    <= STEP_SELF;
            vis_acc_r <= 1'b0;
            state_r   <= S_READ;
          end
        end
        S_READ: begin
          if (step_r == STEP_ZP) begin
            state_r <= S_DRAIN;
          end else begin
            step_r <= step_t'(step_r + 3'd1);
          end
        end
        S_DRAIN: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_cell_kind_r <= KIND_W'(kind_acc_r);
            out_visible_r   <= vis_acc_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a store write only ever comes from an input transfer in idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE))
    else $error("store written outside idle");

  // the last neighbour read is followed by its data and the drain cycle
  a_last_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && step_r == STEP_ZP) |=> (rd_pend_r && state_r == S_DRAIN))
    else $error("read sequence did not drain");

  // a result only appears from the final query state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final query state");

  // no read data is pending once the block is back in idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !rd_pend_r)
    else $error("read pending in idle");

endmodule
